@@ rtl/log_record_stream_deframer_top_assert.svh @@
// assertion macros for the log record stream deframer
`ifndef LOG_RECORD_STREAM_DEFRAMER_TOP_ASSERT_SVH
`define LOG_RECORD_STREAM_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTH
`define LRSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LRSD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRSD_ASSERT(lbl, prop, msg)
`define LRSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/lrsd_pkg.sv @@
// shared types and constants for the log record stream deframer
`timescale 1ns / 1ps

package lrsd_pkg;

	// record header layout, byte offsets
	localparam int unsigned HDR_BYTES = 14;
	localparam logic [3:0] HDR_TOPIC_BASE = 4'd8;
	localparam logic [3:0] HDR_PAYLOAD_BASE = 4'd10;
	localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);

	// byte role tags
	localparam logic [1:0] ROLE_HEADER = 2'd0;
	localparam logic [1:0] ROLE_TOPIC = 2'd1;
	localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
	localparam logic [1:0] ROLE_END = 2'd3;

	localparam int unsigned TDATA_BITS = 160;

	typedef struct packed {
		logic [1:0] role;
		logic [7:0] byte_out;
		logic done;
		logic [63:0] stamp;
		logic [15:0] topic_len;
		logic [31:0] pay_len;
		logic [31:0] count;
		logic partial;
	} lrsd_result_t;

endpackage

@@ rtl/log_record_stream_deframer_top.sv @@
// top level of the log record stream deframer
`timescale 1ns / 1ps
`include "log_record_stream_deframer_top_assert.svh"

// log record stream deframer
// input channel s_*: one stream byte per transfer in s_tdata, s_tuser set
//   asks for the end-of-stream check instead of a byte
// output channel m_*: exactly one result per input transfer, m_tuser gives
//   the byte role (header, topic, payload, end check), m_tdata the byte,
//   record-done flag, current header fields, record count and the
//   trailing-partial flag of the end check
// output: a result is presented from the output register in the cycle after
//   its input transfer
// throughput: one byte per cycle while s_tready is high, the parser state
//   updates in the same cycle the byte is taken
// stall: while the output register holds a result that is not taken,
//   s_tready drops; s_tready is high whenever the register is empty or is
//   being emptied in this cycle
// reset: arst_n clears all parser state and the record count, and empties
//   the output register

module log_record_stream_deframer_top
	import lrsd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,     // data_byte
	input logic s_tuser,           // end_of_stream
	output logic m_tvalid,
	input logic m_tready,
	// byte_out, record_done, timestamp, topic_length, payload_length,
	// records_seen, trailing_partial, zero pad
	output logic [TDATA_BITS-1:0] m_tdata,
	output logic [1:0] m_tuser     // byte_role
);

	lrsd_result_t res;
	lrsd_result_t res_s1;
	logic m_valid_q;
	logic s_xfer;

	// accept when the output register is free or drains this cycle
	assign s_tready = !m_valid_q || m_tready;
	assign s_xfer = s_tvalid && s_tready;

	lrsd_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(s_xfer),
		.data_byte(s_tdata),
		.end_of_stream(s_tuser),
		.res(res)
	);

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	// payload of the output register, no reset needed
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			res_s1 <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser = res_s1.role;
	assign m_tdata = {6'd0, res_s1.partial, res_s1.count, res_s1.pay_len,
		res_s1.topic_len, res_s1.stamp, res_s1.done, res_s1.byte_out};

	`LRSD_ASSERT(a_no_take_on_stall, (m_valid_q && !m_tready) |-> !s_tready,
		"input taken while result stalled")
	`LRSD_ASSERT(a_done_role, (m_valid_q && res_s1.done) |->
		(res_s1.role == ROLE_HEADER || res_s1.role == ROLE_TOPIC),
		"record done on a payload byte or end check")
	`LRSD_ASSERT(a_partial_role, (m_valid_q && res_s1.partial) |-> (res_s1.role == ROLE_END),
		"trailing partial outside end check")

endmodule

@@ rtl/lrsd_parser.sv @@
// record parser state and per-byte next-state logic
`timescale 1ns / 1ps
`include "log_record_stream_deframer_top_assert.svh"

module lrsd_parser
	import lrsd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] data_byte,
	input logic end_of_stream,
	output lrsd_result_t res
);

	logic [3:0] hdr_idx_q, hdr_idx_d;
	logic hdr_complete_q, hdr_complete_d;
	logic [63:0] stamp_q, stamp_d;
	logic [15:0] topic_len_q, topic_len_d;
	logic [31:0] pay_len_q, pay_len_d;
	logic [15:0] topic_taken_q, topic_taken_d;
	logic [31:0] payload_left_q, payload_left_d;
	logic [31:0] count_q, count_d;
	logic [15:0] taken_inc;
	logic finish;

	assign taken_inc = topic_taken_q + 16'd1;

	always_comb begin
		hdr_idx_d = hdr_idx_q;
		hdr_complete_d = hdr_complete_q;
		stamp_d = stamp_q;
		topic_len_d = topic_len_q;
		pay_len_d = pay_len_q;
		topic_taken_d = topic_taken_q;
		payload_left_d = payload_left_q;
		count_d = count_q;
		finish = 1'b0;
		res.role = ROLE_END;
		res.byte_out = data_byte;
		res.partial = 1'b0;

		if (end_of_stream) begin
			res.role = ROLE_END;
			res.byte_out = 8'd0;
			res.partial = (payload_left_q != 32'd0) || hdr_complete_q ||
				(hdr_idx_q != 4'd0) || (topic_taken_q != 16'd0);
		end else if (payload_left_q != 32'd0) begin
			res.role = ROLE_PAYLOAD;
			payload_left_d = payload_left_q - 32'd1;
		end else if (!hdr_complete_q) begin
			res.role = ROLE_HEADER;
			// drop the byte straight into its lane
			for (int i = 0; i < 8; i++) begin
				if (hdr_idx_q == 4'(i)) stamp_d[i*8 +: 8] = data_byte;
			end
			for (int i = 0; i < 2; i++) begin
				if (hdr_idx_q == HDR_TOPIC_BASE + 4'(i)) topic_len_d[i*8 +: 8] = data_byte;
			end
			for (int i = 0; i < 4; i++) begin
				if (hdr_idx_q == HDR_PAYLOAD_BASE + 4'(i)) begin
					pay_len_d[i*8 +: 8] = data_byte;
				end
			end
			if (hdr_idx_q == HDR_LAST) begin
				hdr_idx_d = 4'd0;
				hdr_complete_d = 1'b1;
				topic_taken_d = 16'd0;
				finish = (topic_len_d == 16'd0);
			end else begin
				hdr_idx_d = hdr_idx_q + 4'd1;
			end
		end else begin
			res.role = ROLE_TOPIC;
			topic_taken_d = taken_inc;
			finish = (taken_inc >= topic_len_q);
		end

		// close the record and arm the payload skip
		if (finish) begin
			if (count_q != 32'hFFFF_FFFF) count_d = count_q + 32'd1;
			payload_left_d = pay_len_d;
			topic_taken_d = 16'd0;
			hdr_complete_d = 1'b0;
		end

		res.done = finish;
		res.stamp = stamp_d;
		res.topic_len = topic_len_d;
		res.pay_len = pay_len_d;
		res.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q <= 4'd0;
			hdr_complete_q <= 1'b0;
			stamp_q <= 64'd0;
			topic_len_q <= 16'd0;
			pay_len_q <= 32'd0;
			topic_taken_q <= 16'd0;
			payload_left_q <= 32'd0;
			count_q <= 32'd0;
		end else if (step) begin
			hdr_idx_q <= hdr_idx_d;
			hdr_complete_q <= hdr_complete_d;
			stamp_q <= stamp_d;
			topic_len_q <= topic_len_d;
			pay_len_q <= pay_len_d;
			topic_taken_q <= topic_taken_d;
			payload_left_q <= payload_left_d;
			count_q <= count_d;
		end
	end

	`LRSD_ASSERT(a_hdr_idx_range, hdr_idx_q <= HDR_LAST, "header index past last byte")
	`LRSD_ASSERT(a_complete_idx, hdr_complete_q |-> (hdr_idx_q == 4'd0),
		"header complete with index not cleared")
	`LRSD_ASSERT(a_skip_not_topic, (payload_left_q != 32'd0) |-> !hdr_complete_q,
		"payload skip while topic pending")

endmodule
